>>> hw/rtl/ali_pkg.sv
// Shared types and codes for the array list insert engine.
// No dependencies; used by array_list_insert_engine.
package ali_pkg;

  // Request codes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_LIST   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_FRONT  = 2'd2,
    MODE_AFTER  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_LISTED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  localparam int unsigned ElemWidth  = 32;
  localparam int unsigned PosWidth   = 5;
  localparam int unsigned FillWidth  = 6;
  localparam int unsigned MaxResults = 32;

endpackage

>>> hw/rtl/ali_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; instanced by array_list_insert_engine.
module ali_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/array_list_insert_engine.sv
// Array list insert engine: top level with its request sequencer.
// Depends on ali_pkg (codes and field widths) and ali_ram (element memory).
//
// Usage. Requests arrive on the input channel (in_valid_i, in_stall_o, mode_i,
// value_i, key_i); results leave on the output channel (out_valid_o,
// out_stall_i, status_o, element_o, position_o, fill_count_o, last_o). A
// transfer happens on a rising edge where valid is high and stall is low.
// The block works on one request at a time: in_stall_o stays high from the
// transfer of a request until its last result has been loaded into the output
// register, so the next request can be taken while that result still waits.
// Every request ends in exactly one result with last_o set.
// Steps per request, N the fill count: append goes straight to the write;
// front insert moves all N elements up, a read and a write each, then writes;
// insert after a key reads and compares each element searched, moves each
// element behind it, then writes; a listing reads and loads one element at a
// time, capped at 32 elements. Full and empty answers read no memory, and a
// missing key reads every element. The element memory has one read port.
// Reset empties the list at once (fill count cleared); the memory itself is
// never cleared because only written entries are ever read.
// When the receiver stalls, the output register holds its result and the
// sequencer waits on that result before it loads the next one.
module array_list_insert_engine #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] element_o,
  output logic [4:0]  position_o,
  output logic [5:0]  fill_count_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer states. LIST_RD/LIST_LD walk the list, SRCH_RD/SRCH_CMP look for
  // the key, SHIFT_RD/SHIFT_WR move entries up by one, WRITE places the value.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LIST_RD,
    S_LIST_LD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_EMIT
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [IW-1:0]                   idx_q, idx_d;
  logic [IW-1:0]                   at_q, at_d;
  logic [ali_pkg::ElemWidth-1:0]   value_q, value_d;
  logic [ali_pkg::ElemWidth-1:0]   key_q, key_d;
  ali_pkg::status_e                res_status_q, res_status_d;
  logic [ali_pkg::PosWidth-1:0]    res_pos_q, res_pos_d;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic [2:0]                      status_q, status_d;
  logic [ali_pkg::ElemWidth-1:0]   element_q, element_d;
  logic [ali_pkg::PosWidth-1:0]    position_q, position_d;
  logic [ali_pkg::FillWidth-1:0]   fill_q, fill_d;
  logic                            last_q, last_d;

  // Memory port.
  logic                            ram_we, ram_re;
  logic [IW-1:0]                   ram_waddr, ram_raddr;
  logic [ali_pkg::ElemWidth-1:0]   ram_wdata, ram_rdata;

  logic                            out_load;
  logic                            in_xfer;
  logic                            is_full;
  logic                            idx_is_last;
  logic                            list_last;

  ali_ram #(
    .WIDTH(ali_pkg::ElemWidth),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The output register may take a new result when it is empty or drains now.
  assign out_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign is_full     = (count_q == CW'(CAPACITY));
  // True when idx_q addresses the final stored element.
  assign idx_is_last = ((CW'(idx_q) + CW'(1)) == count_q);
  // A listing ends at the final element or after 32 results, whichever is first.
  assign list_last   = idx_is_last ||
                       (ali_pkg::PosWidth'(idx_q) == ali_pkg::PosWidth'(ali_pkg::MaxResults - 1));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    at_d         = at_q;
    value_d      = value_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;

    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    element_d    = element_q;
    position_d   = position_q;
    fill_d       = fill_q;
    last_d       = last_q;

    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          value_d   = value_i;
          key_d     = key_i;
          idx_d     = '0;
          res_pos_d = '0;
          case (ali_pkg::mode_e'(mode_i))
            ali_pkg::MODE_LIST: begin
              if (count_q == '0) begin
                res_status_d = ali_pkg::ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            default: begin
              if (is_full) begin
                res_status_d = ali_pkg::ST_FULL;
                state_d      = S_EMIT;
              end else begin
                case (ali_pkg::mode_e'(mode_i))
                  ali_pkg::MODE_APPEND: begin
                    at_d    = IW'(count_q);
                    state_d = S_WRITE;
                  end
                  ali_pkg::MODE_FRONT: begin
                    at_d    = '0;
                    idx_d   = IW'(count_q);
                    state_d = S_SHIFT_RD;
                  end
                  default: begin
                    if (count_q == '0) begin
                      res_status_d = ali_pkg::ST_NOT_FOUND;
                      state_d      = S_EMIT;
                    end else begin
                      state_d = S_SRCH_RD;
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end

      S_LIST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_LIST_LD;
      end

      S_LIST_LD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          status_d    = ali_pkg::ST_LISTED;
          element_d   = ram_rdata;
          position_d  = ali_pkg::PosWidth'(idx_q);
          fill_d      = ali_pkg::FillWidth'(count_q);
          last_d      = list_last;
          idx_d       = idx_q + IW'(1);
          state_d     = list_last ? S_IDLE : S_LIST_RD;
        end
      end

      S_SRCH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (ram_rdata == key_q) begin
          // Key found: open a gap right behind it.
          at_d    = idx_q + IW'(1);
          idx_d   = IW'(count_q);
          state_d = S_SHIFT_RD;
        end else if (idx_is_last) begin
          res_status_d = ali_pkg::ST_NOT_FOUND;
          res_pos_d    = '0;
          state_d      = S_EMIT;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_SRCH_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_q == at_q) begin
          state_d = S_WRITE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q - IW'(1);
          state_d   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_q - IW'(1);
        state_d   = S_SHIFT_RD;
      end

      S_WRITE: begin
        ram_we       = 1'b1;
        ram_waddr    = at_q;
        ram_wdata    = value_q;
        count_d      = count_q + CW'(1);
        res_status_d = ali_pkg::ST_INSERTED;
        res_pos_d    = ali_pkg::PosWidth'(at_q);
        state_d      = S_EMIT;
      end

      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          element_d   = '0;
          position_d  = res_pos_q;
          fill_d      = ali_pkg::FillWidth'(count_q);
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    at_q         <= at_d;
    value_q      <= value_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    status_q     <= status_d;
    element_q    <= element_d;
    position_q   <= position_d;
    fill_q       <= fill_d;
    last_q       <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign element_o    = element_q;
  assign position_o   = position_q;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

endmodule
